[src/pvsa_pkg.sv]
// pvsa_pkg: shared widths, codes and types for the voice slot allocator
// used by pvsa_cell, the top level and the checker; depends on nothing
package pvsa_pkg;

  localparam int SLOTS  = 8;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int MASK_W = 8;

  // input word kinds (tuser)
  localparam logic [1:0] KIND_ON    = 2'd0;
  localparam logic [1:0] KIND_OFF   = 2'd1;
  localparam logic [1:0] KIND_BLOCK = 2'd2;
  localparam logic [1:0] KIND_NONE  = 2'd3;

  // result status (tuser on the output side)
  localparam logic [2:0] STAT_FILTERED = 3'd0;
  localparam logic [2:0] STAT_ASSIGNED = 3'd1;
  localparam logic [2:0] STAT_HELD     = 3'd2;
  localparam logic [2:0] STAT_NO_SLOT  = 3'd3;
  localparam logic [2:0] STAT_RELEASED = 3'd4;
  localparam logic [2:0] STAT_NOT_HELD = 3'd5;
  localparam logic [2:0] STAT_BLOCK    = 3'd6;

  // per-slot block actions
  localparam logic [2:0] ACT_FADE = 3'd0;
  localparam logic [2:0] ACT_COLD = 3'd1;
  localparam logic [2:0] ACT_IDLE = 3'd2;
  localparam logic [2:0] ACT_WARM = 3'd3;
  localparam logic [2:0] ACT_PLAY = 3'd4;

  // configuration register indexes
  localparam logic REG_LISTEN = 1'b0;
  localparam logic REG_WARMUP = 1'b1;

  localparam logic [15:0] WARMUP_RESET = 16'd256;

  typedef logic [SLOT_W-1:0] slot_t;

  // search results handed from cell to cell during a note scan
  typedef struct packed {
    logic  hit;
    slot_t hit_slot;
    logic  fs;
    slot_t fs_slot;
    logic  ff;
    slot_t ff_slot;
  } acc_t;

  // command broadcast from the sequencer to every cell
  typedef struct packed {
    logic        scan;
    logic        blk;
    slot_t       pos;
    logic [6:0]  note;
    logic        mode;
    logic        stable;
    logic [13:0] blen;
    logic [15:0] wlen;
    logic        wr;
    logic        wr_set;
    slot_t       wr_slot;
  } cell_cmd_t;

endpackage

[src/pvsa_cell.sv]
// pvsa_cell: one voice slot: held note, warm-up counter, engine cold flag
// and the scan stage that passes search results to the next cell; uses pvsa_pkg
module pvsa_cell (
  input  logic                clk,
  input  logic                rst,
  input  pvsa_pkg::slot_t     idx,
  input  logic                silent,
  input  pvsa_pkg::cell_cmd_t cmd,
  input  pvsa_pkg::acc_t      acc_in,
  output pvsa_pkg::acc_t      acc_out,
  output logic [2:0]          res_act,
  output logic [6:0]          res_note
);

  logic        valid;
  logic        cold;
  logic [6:0]  note;
  logic [15:0] count;

  logic        here;
  logic        wants;
  logic        cold_next;
  logic [15:0] count_next;
  logic [15:0] blen_ext;
  pvsa_pkg::acc_t acc_c;

  assign here     = (cmd.pos == idx);
  assign wants    = cmd.mode & valid & cmd.stable;
  assign blen_ext = {2'b00, cmd.blen};

  always_comb begin
    cold_next  = cold;
    count_next = count;
    res_act    = pvsa_pkg::ACT_IDLE;
    if (!wants) begin
      if (!silent) begin
        res_act = pvsa_pkg::ACT_FADE;
      end else if (!cold) begin
        cold_next = 1'b1;
        res_act   = pvsa_pkg::ACT_COLD;
      end else begin
        res_act = pvsa_pkg::ACT_IDLE;
      end
      count_next = cold_next ? cmd.wlen : 16'd0;
    end else if (count != 16'd0) begin
      // saturating countdown
      count_next = (count > blen_ext) ? (count - blen_ext) : 16'd0;
      cold_next  = 1'b0;
      res_act    = pvsa_pkg::ACT_WARM;
    end else begin
      cold_next = 1'b0;
      res_act   = pvsa_pkg::ACT_PLAY;
    end
  end

  assign res_note = valid ? note : 7'd0;

  // first held match, first free silent slot, first free slot
  always_comb begin
    acc_c = acc_in;
    if (valid && (note == cmd.note) && !acc_in.hit) begin
      acc_c.hit      = 1'b1;
      acc_c.hit_slot = idx;
    end
    if (!valid && silent && !acc_in.fs) begin
      acc_c.fs      = 1'b1;
      acc_c.fs_slot = idx;
    end
    if (!valid && !acc_in.ff) begin
      acc_c.ff      = 1'b1;
      acc_c.ff_slot = idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      cold  <= 1'b1;
      count <= 16'd0;
    end else begin
      if (cmd.blk && here) begin
        cold  <= cold_next;
        count <= count_next;
      end
      if (cmd.wr && (cmd.wr_slot == idx)) begin
        valid <= cmd.wr_set;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr && cmd.wr_set && (cmd.wr_slot == idx)) begin
      note <= cmd.note;
    end
    if (cmd.scan && here) begin
      acc_out <= acc_c;
    end
  end

endmodule

[src/poly_voice_slot_allocator_unit.sv]
// poly_voice_slot_allocator_unit: top level, sequencer, config registers,
// output register and the row of pvsa_cell slots; uses pvsa_pkg and pvsa_cell
//
// Maps MIDI note-on/note-off words onto SLOTS voice slots and, on each end of
// audio block word, reports one action per slot in slot order (tlast on the
// last one). One input word is handled at a time. A note word walks the row
// of slot cells one cell per cycle to find a holding, free-and-silent or free
// slot, then decides in the DECIDE state, which waits for a free output
// register before it returns to idle. A block word visits one cell per cycle
// while the output is free and emits that slot's result. Kind 3 words are
// taken and dropped. Configuration is written with cfg_we/cfg_index/cfg_data;
// the user must write it only while idle, which the block does not enforce.
module poly_voice_slot_allocator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // note[6:0], velocity[13:7], channel[18:14], silent_mask[26:19],
  // mode_active[27], input_stable[28], block_length[42:29], zero fill
  input  logic [47:0] s_tdata,
  // kind[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // slot[2:0], slot_note[9:3], action[12:10], zero fill
  output logic [15:0] m_tdata,
  // note_status[2:0]
  output logic [2:0]  m_tuser,
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_BLOCK  = 4'b0100,
    ST_DECIDE = 4'b1000
  } state_t;

  state_t              state;
  pvsa_pkg::slot_t     pos;

  logic [1:0]          kind_r;
  logic [6:0]          note_r;
  logic [6:0]          vel_r;
  logic [4:0]          chan_r;
  logic [pvsa_pkg::MASK_W-1:0] mask_r;
  logic                mode_r;
  logic                stable_r;
  logic [13:0]         blen_r;

  logic [4:0]          listen_channel;
  logic [15:0]         warmup_length;

  logic [2:0]          status_r;
  logic [2:0]          slot_r;
  logic [6:0]          snote_r;
  logic [2:0]          act_r;
  logic                last_r;

  logic                free;
  logic                last_pos;
  logic                load;
  logic                accept;

  pvsa_pkg::cell_cmd_t cmd;
  pvsa_pkg::acc_t      acc [pvsa_pkg::SLOTS];
  logic [2:0]          res_act [pvsa_pkg::SLOTS];
  logic [6:0]          res_note [pvsa_pkg::SLOTS];
  logic [pvsa_pkg::SLOTS-1:0] silent;

  pvsa_pkg::acc_t      fin;
  logic                filtered;
  logic                note_on;
  logic [2:0]          dec_status;
  pvsa_pkg::slot_t     dec_slot;
  logic [6:0]          dec_note;
  logic                dec_wr;
  logic                dec_set;

  assign s_tready = (state == ST_IDLE) && !rst;
  assign accept   = s_tvalid && s_tready;
  assign free     = !m_tvalid || m_tready;
  assign last_pos = (pos == pvsa_pkg::SLOT_W'(pvsa_pkg::SLOTS - 1));
  assign load     = free && ((state == ST_BLOCK) || (state == ST_DECIDE));

  // slots beyond the mask count as silent
  genvar gi;
  generate
    for (gi = 0; gi < pvsa_pkg::SLOTS; gi++) begin : g_slot
      pvsa_pkg::acc_t acc_in;
      if (gi < pvsa_pkg::MASK_W) begin : g_mask
        assign silent[gi] = mask_r[gi];
      end else begin : g_nomask
        assign silent[gi] = 1'b1;
      end
      if (gi == 0) begin : g_head
        assign acc_in = '0;
      end else begin : g_link
        assign acc_in = acc[gi-1];
      end
      pvsa_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .idx      (pvsa_pkg::SLOT_W'(gi)),
        .silent   (silent[gi]),
        .cmd      (cmd),
        .acc_in   (acc_in),
        .acc_out  (acc[gi]),
        .res_act  (res_act[gi]),
        .res_note (res_note[gi])
      );
    end
  endgenerate

  // note word decision from the search result at the end of the row
  assign fin      = acc[pvsa_pkg::SLOTS-1];
  assign filtered = (listen_channel != 5'd0) && (chan_r != listen_channel);
  assign note_on  = (kind_r == pvsa_pkg::KIND_ON) && (vel_r != 7'd0);

  always_comb begin
    dec_status = pvsa_pkg::STAT_FILTERED;
    dec_slot   = '0;
    dec_note   = 7'd0;
    dec_wr     = 1'b0;
    dec_set    = 1'b0;
    if (filtered) begin
      dec_status = pvsa_pkg::STAT_FILTERED;
    end else if (note_on) begin
      if (fin.hit) begin
        dec_status = pvsa_pkg::STAT_HELD;
        dec_slot   = fin.hit_slot;
        dec_note   = note_r;
      end else if (fin.fs) begin
        dec_status = pvsa_pkg::STAT_ASSIGNED;
        dec_slot   = fin.fs_slot;
        dec_note   = note_r;
        dec_wr     = 1'b1;
        dec_set    = 1'b1;
      end else if (fin.ff) begin
        dec_status = pvsa_pkg::STAT_ASSIGNED;
        dec_slot   = fin.ff_slot;
        dec_note   = note_r;
        dec_wr     = 1'b1;
        dec_set    = 1'b1;
      end else begin
        dec_status = pvsa_pkg::STAT_NO_SLOT;
      end
    end else if (fin.hit) begin
      dec_status = pvsa_pkg::STAT_RELEASED;
      dec_slot   = fin.hit_slot;
      dec_note   = note_r;
      dec_wr     = 1'b1;
    end else begin
      dec_status = pvsa_pkg::STAT_NOT_HELD;
    end
  end

  always_comb begin
    cmd.scan    = (state == ST_SCAN);
    cmd.blk     = (state == ST_BLOCK) && free;
    cmd.pos     = pos;
    cmd.note    = note_r;
    cmd.mode    = mode_r;
    cmd.stable  = stable_r;
    cmd.blen    = blen_r;
    cmd.wlen    = warmup_length;
    cmd.wr      = (state == ST_DECIDE) && free && dec_wr;
    cmd.wr_set  = dec_set;
    cmd.wr_slot = dec_slot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pos   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            pos <= '0;
            case (s_tuser)
              pvsa_pkg::KIND_ON:    state <= ST_SCAN;
              pvsa_pkg::KIND_OFF:   state <= ST_SCAN;
              pvsa_pkg::KIND_BLOCK: state <= ST_BLOCK;
              default:              state <= ST_IDLE;
            endcase
          end
        end
        ST_SCAN: begin
          pos <= pos + 1'b1;
          if (last_pos) begin
            state <= ST_DECIDE;
          end
        end
        ST_BLOCK: begin
          if (free) begin
            pos <= pos + 1'b1;
            if (last_pos) begin
              state <= ST_IDLE;
            end
          end
        end
        ST_DECIDE: begin
          if (free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r   <= s_tuser;
      note_r   <= s_tdata[6:0];
      vel_r    <= s_tdata[13:7];
      chan_r   <= s_tdata[18:14];
      mask_r   <= s_tdata[26:19];
      mode_r   <= s_tdata[27];
      stable_r <= s_tdata[28];
      blen_r   <= s_tdata[42:29];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      listen_channel <= 5'd0;
      warmup_length  <= pvsa_pkg::WARMUP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        pvsa_pkg::REG_LISTEN: listen_channel <= cfg_data[4:0];
        pvsa_pkg::REG_WARMUP: warmup_length  <= cfg_data;
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (state == ST_BLOCK) begin
        status_r <= pvsa_pkg::STAT_BLOCK;
        slot_r   <= 3'(pos);
        snote_r  <= res_note[pos];
        act_r    <= res_act[pos];
        last_r   <= last_pos;
      end else begin
        status_r <= dec_status;
        slot_r   <= 3'(dec_slot);
        snote_r  <= dec_note;
        act_r    <= pvsa_pkg::ACT_FADE;
        last_r   <= 1'b1;
      end
    end
  end

  assign m_tdata = {3'b000, act_r, snote_r, slot_r};
  assign m_tuser = status_r;
  assign m_tlast = last_r;

endmodule

[src/pvsa_checker.sv]
// pvsa_checker: port-level checks on the voice slot allocator, bound to
// poly_voice_slot_allocator_unit; uses pvsa_pkg
module pvsa_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tlast
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("output word changed while stalled");

  // a note result is a single word and carries the fade action code
  a_note_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != pvsa_pkg::STAT_BLOCK) |-> m_tlast
      && (m_tdata[12:10] == pvsa_pkg::ACT_FADE))
    else $error("note result not single or carries an action");

  // block actions stay within the defined codes
  a_block_act: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == pvsa_pkg::STAT_BLOCK) |-> m_tdata[12:10] <= pvsa_pkg::ACT_PLAY)
    else $error("undefined block action");

  // a real event keeps the input closed while it is worked on
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser != pvsa_pkg::KIND_NONE) |=> !s_tready)
    else $error("input taken while an event is in progress");

  // no undefined status code ever shows
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser != 3'd7)
    else $error("undefined status code");

endmodule

bind poly_voice_slot_allocator_unit pvsa_checker u_pvsa_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
